### rtl/irr_pkg.sv
package irr_pkg;

    localparam int unsigned ROUTE_LINES = 32;
    localparam int unsigned NUM_CORES   = 4;

    localparam logic [7:0] PENDING_OFFSET      = 8'd32;
    localparam logic [7:0] ENABLE_OFFSET       = 8'd36;
    localparam logic [7:0] ENABLE_SET_OFFSET   = 8'd40;
    localparam logic [7:0] ENABLE_CLEAR_OFFSET = 8'd44;
    localparam logic [7:0] EDGE_OFFSET         = 8'd56;
    localparam logic [7:0] CORE_STATUS_BASE    = 8'd64;

    localparam logic [2:0] PIN_BASE = 3'd2;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;

    localparam logic [3:0] SIZE_WORD = 4'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  address;
        logic [3:0]  access_size;
        logic [63:0] write_data;
        logic [4:0]  irq_number;
        logic        line_level;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        event_valid;
        logic [1:0]  target_core;
        logic [2:0]  target_pin;
        logic        assert_flag;
        logic        last_result;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_byte;
        logic adv;
        logic ev_lo;
        logic ev_hi;
        logic ev_line;
        logic close;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] mode;
        logic       size_ok;
        logic       last_byte;
        logic       route_diff;
        logic       out_free;
    } sts_t;

endpackage

### rtl/irr_ctrl.sv
module irr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  irr_pkg::sts_t sts,
    output irr_pkg::cmd_t cmd
);
    import irr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WB    = 3'd3;
    localparam logic [2:0] S_EVLO  = 3'd4;
    localparam logic [2:0] S_EVHI  = 3'd5;
    localparam logic [2:0] S_LINE  = 3'd6;
    localparam logic [2:0] S_CLOSE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.mode)
                    MODE_READ:  state_next = sts.size_ok ? S_RD : S_CLOSE;
                    MODE_WRITE: state_next = sts.size_ok ? S_WB : S_CLOSE;
                    MODE_LINE:  state_next = S_LINE;
                    default:    state_next = S_CLOSE;
                endcase
            end
            S_RD:
            begin
                cmd.rd_byte = 1'b1;
                cmd.adv     = 1'b1;
                if (sts.last_byte)
                    state_next = S_CLOSE;
            end
            S_WB:
            begin
                if (sts.route_diff)
                    state_next = S_EVLO;
                else
                begin
                    cmd.adv = 1'b1;
                    if (sts.last_byte)
                        state_next = S_CLOSE;
                end
            end
            S_EVLO:
            begin
                if (sts.out_free)
                begin
                    cmd.ev_lo  = 1'b1;
                    state_next = S_EVHI;
                end
            end
            S_EVHI:
            begin
                if (sts.out_free)
                begin
                    cmd.ev_hi  = 1'b1;
                    cmd.adv    = 1'b1;
                    state_next = sts.last_byte ? S_CLOSE : S_WB;
                end
            end
            S_LINE:
            begin
                if (sts.out_free)
                begin
                    cmd.ev_line = 1'b1;
                    state_next  = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.close  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/irr_dp.sv
module irr_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  irr_pkg::req_t req_data,
    input  irr_pkg::cmd_t cmd,
    output irr_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output irr_pkg::rsp_t rsp_data
);
    import irr_pkg::*;

    logic [7:0]  route_reg [ROUTE_LINES];
    logic [31:0] enable_reg;
    logic [31:0] pending_reg;
    logic [31:0] edge_reg;
    logic [31:0] core_reg [NUM_CORES];

    req_t        item_reg;
    logic [2:0]  idx_reg;
    logic [63:0] rd_reg;
    logic        out_valid_reg;
    rsp_t        out_reg;

    logic [8:0]  byte_addr;
    logic [7:0]  wrap_addr;
    logic [7:0]  wr_byte;
    logic [4:0]  route_idx;
    logic [7:0]  route_rd;
    logic [7:0]  rd_byte;
    logic [7:0]  d_pend;
    logic [7:0]  d_en;
    logic [7:0]  d_edge;
    logic [7:0]  d_core;

    logic        ev_go;
    logic        ev_level;
    logic [31:0] ev_bit;
    logic        ev_enabled;
    logic [2:0]  ev_pin;
    logic        ev_has_core;
    logic [1:0]  ev_core;
    logic [31:0] ev_status_set;
    logic [31:0] ev_status_clr;
    logic        ev_emit;

    logic        word_write;
    logic [31:0] word_v;
    logic [31:0] enable_next;
    logic [31:0] pending_next;
    logic [31:0] edge_next;

    logic        out_free;

    assign byte_addr = {1'b0, item_reg.address} + {6'b0, idx_reg};
    assign wrap_addr = byte_addr[7:0];
    assign wr_byte   = item_reg.write_data[{idx_reg, 3'b000} +: 8];
    assign route_idx = (item_reg.mode == MODE_LINE) ? item_reg.irq_number : byte_addr[4:0];
    assign route_rd  = route_reg[route_idx];

    assign d_pend = wrap_addr - PENDING_OFFSET;
    assign d_en   = wrap_addr - ENABLE_OFFSET;
    assign d_edge = wrap_addr - EDGE_OFFSET;
    assign d_core = wrap_addr - CORE_STATUS_BASE;

    // window byte decode, route bytes first
    always_comb
    begin
        rd_byte = 8'h00;
        if (wrap_addr[7:5] == 3'b000)
            rd_byte = route_rd;
        else if (d_pend < 8'd4)
            rd_byte = pending_reg[{d_pend[1:0], 3'b000} +: 8];
        else if (d_en < 8'd4)
            rd_byte = enable_reg[{d_en[1:0], 3'b000} +: 8];
        else if (d_edge < 8'd4)
            rd_byte = edge_reg[{d_edge[1:0], 3'b000} +: 8];
        else if (d_core < 8'd32 && !d_core[2])
            rd_byte = core_reg[d_core[4:3]][{d_core[1:0], 3'b000} +: 8];
    end

    assign ev_go      = cmd.ev_lo | cmd.ev_hi | cmd.ev_line;
    assign ev_level   = cmd.ev_line ? item_reg.line_level : cmd.ev_hi;
    assign ev_bit     = 32'd1 << route_idx;
    assign ev_enabled = enable_reg[route_idx];

    // highest pin bit picks the pin, lowest core bit picks the core
    always_comb
    begin
        ev_pin = PIN_BASE;
        for (int k = 0; k < 4; k++)
        begin
            if (route_rd[4 + k])
                ev_pin = PIN_BASE + 3'(k);
        end
        ev_core = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (route_rd[k])
                ev_core = 2'(k);
        end
    end

    assign ev_has_core   = |route_rd[3:0];
    assign ev_status_set = core_reg[ev_core] | ev_bit;
    assign ev_status_clr = core_reg[ev_core] & ~ev_bit;
    assign ev_emit       = ev_go && ev_enabled && ev_has_core
                           && (ev_level || (ev_status_clr == 32'd0));

    assign word_write = cmd.close && (item_reg.mode == MODE_WRITE)
                        && (item_reg.access_size == SIZE_WORD);
    assign word_v     = item_reg.write_data[31:0];

    // set, clear, edge applied in that order
    always_comb
    begin
        enable_next  = enable_reg;
        pending_next = pending_reg;
        edge_next    = edge_reg;
        if (item_reg.address == ENABLE_SET_OFFSET)
            enable_next = enable_next | word_v;
        if (item_reg.address == ENABLE_CLEAR_OFFSET)
        begin
            enable_next  = enable_next & ~word_v;
            pending_next = pending_next & ~(~word_v & edge_reg);
        end
        if (item_reg.address == EDGE_OFFSET)
            edge_next = word_v;
    end

    assign out_free = !out_valid_reg || rsp_ready;

    assign sts.mode       = item_reg.mode;
    assign sts.size_ok    = (item_reg.access_size == 4'd1) || (item_reg.access_size == 4'd2)
                            || (item_reg.access_size == 4'd4)
                            || (item_reg.access_size == 4'd8);
    assign sts.last_byte  = ({1'b0, idx_reg} == (item_reg.access_size - 4'd1));
    assign sts.route_diff = (byte_addr[8:5] == 4'd0) && (route_rd != wr_byte);
    assign sts.out_free   = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROUTE_LINES; i++)
                route_reg[i] <= 8'h00;
            for (int c = 0; c < NUM_CORES; c++)
                core_reg[c] <= 32'd0;
            enable_reg    <= 32'd0;
            pending_reg   <= 32'd0;
            edge_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_go && ev_enabled)
            begin
                pending_reg[route_idx] <= ev_level;
                if (ev_has_core)
                    core_reg[ev_core] <= ev_level ? ev_status_set : ev_status_clr;
            end
            if (cmd.ev_lo)
                route_reg[byte_addr[4:0]] <= wr_byte;
            if (word_write)
            begin
                enable_reg  <= enable_next;
                pending_reg <= pending_next;
                edge_reg    <= edge_next;
            end
            if (ev_emit || cmd.close)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req_data;
            idx_reg  <= 3'd0;
            rd_reg   <= 64'd0;
        end
        else
        begin
            if (cmd.rd_byte)
                rd_reg[{idx_reg, 3'b000} +: 8] <= rd_byte;
            if (cmd.adv)
                idx_reg <= idx_reg + 3'd1;
        end
        if (ev_emit)
        begin
            out_reg.read_data   <= 64'd0;
            out_reg.event_valid <= 1'b1;
            out_reg.target_core <= ev_core;
            out_reg.target_pin  <= ev_pin;
            out_reg.assert_flag <= ev_level;
            out_reg.last_result <= 1'b0;
        end
        else if (cmd.close)
        begin
            out_reg.read_data   <= rd_reg;
            out_reg.event_valid <= 1'b0;
            out_reg.target_core <= 2'd0;
            out_reg.target_pin  <= 3'd0;
            out_reg.assert_flag <= 1'b0;
            out_reg.last_result <= 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

### rtl/interrupt_router_regs_unit.sv
// A read gathers its bytes one at a time and then queues its result; a line event queues
// its pin event, if any, ahead of its closing result. A write steps through its bytes; each
// route byte that changes may give a release event on its old route, then an assert on the new.
// One request at a time: the next is taken the cycle after the closing result is queued.
// Reset clears the route table, all status words and the output valid flag at once.
module interrupt_router_regs_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  irr_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output irr_pkg::rsp_t rsp_data
);
    import irr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    irr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    irr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

### rtl/irr_checker.sv
module irr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input irr_pkg::rsp_t rsp_data
);
    import irr_pkg::*;

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed or dropped");

    // one request in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in flight");

    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.event_valid |-> rsp_data.last_result)
        else $error("non-event result without last flag");

    a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.event_valid |->
            !rsp_data.last_result && (rsp_data.read_data == 64'd0)
            && (rsp_data.target_pin >= 3'd2) && (rsp_data.target_pin <= 3'd5))
        else $error("malformed pin event");

endmodule

bind interrupt_router_regs_unit irr_checker u_irr_checker (.*);

### tb/sv/tb_interrupt_router_regs_unit.sv
`timescale 1ns / 100ps

module tb_interrupt_router_regs_unit;

    import irr_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int HOLD_OFF_AT   = 40;
    localparam int RANDOM_ITEMS  = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;

    // shadow copy of the router state
    logic [7:0]  route_bytes [ROUTE_LINES];
    logic [31:0] enabled_lines;
    logic [31:0] pending_lines;
    logic [31:0] edge_lines;
    logic [31:0] core_lines [NUM_CORES];

    req_t request_queue [$];
    rsp_t outputs_due [$];

    int   error_count = 0;
    int   accepted_count = 0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   ready_gap = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    bit   quiet = 1'b0;
    int   quiet_timer = 300;
    rsp_t due_rsp;

    interrupt_router_regs_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int draw_gap();
        int pick;
        if (quiet)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit size_valid(input logic [3:0] size);
        return size == 4'd1 || size == 4'd2 || size == SIZE_WORD || size == 4'd8;
    endfunction

    function automatic void queue_pin_event(input int core, input logic [2:0] pin,
                                            input bit raise);
        rsp_t r;
        r = '0;
        r.event_valid = 1'b1;
        r.target_core = core[1:0];
        r.target_pin  = pin;
        r.assert_flag = raise;
        outputs_due.push_back(r);
    endfunction

    function automatic void line_event(input int line, input bit level);
        logic [31:0] line_bit;
        logic [7:0]  rb;
        logic [2:0]  pin;
        bit          hit;
        int          k;
        line_bit = 32'd1 << line;
        if ((enabled_lines & line_bit) == 32'd0)
            return;
        rb  = route_bytes[line];
        pin = PIN_BASE;
        for (k = 0; k < 4; k++)
            if (rb[4 + k])
                pin = PIN_BASE + 3'(k);
        if (level)
            pending_lines |= line_bit;
        else
            pending_lines &= ~line_bit;
        // only the lowest core in the mask takes the event
        hit = 1'b0;
        for (k = 0; k < NUM_CORES; k++) begin
            if (!hit && rb[k]) begin
                hit = 1'b1;
                if (level) begin
                    core_lines[k] |= line_bit;
                    queue_pin_event(k, pin, 1'b1);
                end
                else begin
                    core_lines[k] &= ~line_bit;
                    if (core_lines[k] == 32'd0)
                        queue_pin_event(k, pin, 1'b0);
                end
            end
        end
    endfunction

    function automatic logic [7:0] window_byte(input logic [7:0] a);
        int d;
        if (a < ROUTE_LINES)
            return route_bytes[a];
        d = int'(a) - int'(PENDING_OFFSET);
        if (d >= 0 && d < 4)
            return pending_lines[8*d +: 8];
        d = int'(a) - int'(ENABLE_OFFSET);
        if (d >= 0 && d < 4)
            return enabled_lines[8*d +: 8];
        d = int'(a) - int'(EDGE_OFFSET);
        if (d >= 0 && d < 4)
            return edge_lines[8*d +: 8];
        d = int'(a) - int'(CORE_STATUS_BASE);
        if (d >= 0 && d < 32 && (d % 8) < 4)
            return core_lines[d / 8][8*(d % 8) +: 8];
        return 8'h00;
    endfunction

    function automatic void compute_router_outputs(input req_t q);
        logic [63:0] rd;
        logic [31:0] v;
        logic [7:0]  nb;
        int          a;
        int          i;
        rsp_t        closing;
        rd = '0;
        v  = q.write_data[31:0];
        if (q.mode == MODE_READ) begin
            if (size_valid(q.access_size))
                for (i = 0; i < q.access_size; i++)
                    rd[8*i +: 8] = window_byte(q.address + 8'(i));
        end
        else if (q.mode == MODE_WRITE) begin
            if (size_valid(q.access_size)) begin
                // route bytes past the table end are dropped, no wrap on writes
                for (i = 0; i < q.access_size; i++) begin
                    a  = int'(q.address) + i;
                    nb = q.write_data[8*i +: 8];
                    if (a < ROUTE_LINES && route_bytes[a] != nb) begin
                        line_event(a, 1'b0);
                        route_bytes[a] = nb;
                        line_event(a, 1'b1);
                    end
                end
                if (q.access_size == SIZE_WORD) begin
                    if (q.address == ENABLE_SET_OFFSET)
                        enabled_lines |= v;
                    if (q.address == ENABLE_CLEAR_OFFSET) begin
                        enabled_lines &= ~v;
                        pending_lines &= ~(~v & edge_lines);
                    end
                    if (q.address == EDGE_OFFSET)
                        edge_lines = v;
                end
            end
        end
        else if (q.mode == MODE_LINE) begin
            line_event(int'(q.irq_number), q.line_level);
        end
        closing = '0;
        closing.read_data   = rd;
        closing.last_result = 1'b1;
        outputs_due.push_back(closing);
    endfunction

    function automatic req_t make_req(input logic [1:0] mode, input logic [7:0] addr,
                                      input logic [3:0] size, input logic [63:0] data,
                                      input logic [4:0] line, input logic level);
        req_t q;
        q.mode        = mode;
        q.address     = addr;
        q.access_size = size;
        q.write_data  = data;
        q.irq_number  = line;
        q.line_level  = level;
        return q;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req_data  <= '0;
            send_gap  = 0;
        end
        else begin
            if (req_valid && req_ready) begin
                compute_router_outputs(req_data);
                accepted_count <= accepted_count + 1;
                send_gap = draw_gap();
            end
            if (req_valid && !req_ready) begin
                // hold the request until taken
            end
            else if (send_gap > 0) begin
                req_valid <= 1'b0;
                send_gap--;
            end
            else if (request_queue.size() > 0) begin
                req_data  <= request_queue.pop_front();
                req_valid <= 1'b1;
            end
            else begin
                req_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_count == HOLD_OFF_AT) begin
            hold_left <= HOLD_OFF_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // alternate stretches with and without idling
    always @(posedge clk)
    begin
        if (!rst_n) begin
            quiet       <= 1'b0;
            quiet_timer <= 300;
        end
        else if (quiet_timer == 0) begin
            quiet       <= !quiet;
            quiet_timer <= $urandom_range(100, 500);
        end
        else begin
            quiet_timer <= quiet_timer - 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            ready_gap = 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (outputs_due.size() == 0) begin
                    $error("unexpected result %h", rsp_data);
                    error_count++;
                end
                else begin
                    due_rsp = outputs_due.pop_front();
                    check_field("read_data", due_rsp.read_data, rsp_data.read_data);
                    check_field("event_valid", due_rsp.event_valid, rsp_data.event_valid);
                    check_field("target_core", due_rsp.target_core, rsp_data.target_core);
                    check_field("target_pin", due_rsp.target_pin, rsp_data.target_pin);
                    check_field("assert_flag", due_rsp.assert_flag, rsp_data.assert_flag);
                    check_field("last_result", due_rsp.last_result, rsp_data.last_result);
                end
                ready_gap = draw_gap();
            end
            if (hold_left > 0) begin
                rsp_ready <= 1'b0;
            end
            else if (ready_gap > 0) begin
                rsp_ready <= 1'b0;
                ready_gap--;
            end
            else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        req_t        q;
        int          n;
        int          pick;
        logic [7:0]  word_addr [3];

        for (n = 0; n < ROUTE_LINES; n++)
            route_bytes[n] = 8'h00;
        for (n = 0; n < NUM_CORES; n++)
            core_lines[n] = 32'd0;
        enabled_lines = 32'd0;
        pending_lines = 32'd0;
        edge_lines    = 32'd0;
        word_addr[0]  = ENABLE_SET_OFFSET;
        word_addr[1]  = ENABLE_CLEAR_OFFSET;
        word_addr[2]  = EDGE_OFFSET;

        // directed part
        request_queue.push_back(make_req(MODE_READ, 8'd0, 4'd8, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_WRITE, ENABLE_SET_OFFSET, SIZE_WORD,
                                         64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_WRITE, EDGE_OFFSET, SIZE_WORD,
                                         64'h0000_FFFF_A5A5_00FF, 5'd0, 1'b0));
        // empty pin nibble on line 0, empty core mask on line 7
        request_queue.push_back(make_req(MODE_WRITE, 8'd0, 4'd8,
                                         64'h8041_2213_F400_1801, 5'd0, 1'b0));
        // upper half falls past the route table
        request_queue.push_back(make_req(MODE_WRITE, 8'd28, 4'd8,
                                         64'hFFFF_FFFF_8F4C_2A11, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_LINE, 8'd0, 4'd0, '0, 5'd31, 1'b1));
        request_queue.push_back(make_req(MODE_LINE, 8'd0, 4'd0, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_LINE, 8'd0, 4'd0, '0, 5'd7, 1'b1));
        request_queue.push_back(make_req(MODE_WRITE, ENABLE_CLEAR_OFFSET, SIZE_WORD,
                                         64'h0000_0000_00FF_FF00, 5'd0, 1'b0));
        // line 12 is now disabled
        request_queue.push_back(make_req(MODE_LINE, 8'd0, 4'd0, '0, 5'd12, 1'b1));
        request_queue.push_back(make_req(MODE_READ, PENDING_OFFSET, SIZE_WORD, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, ENABLE_OFFSET, SIZE_WORD, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, EDGE_OFFSET, 4'd8, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, CORE_STATUS_BASE, 4'd8, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, CORE_STATUS_BASE + 8'd16, SIZE_WORD,
                                         '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, ENABLE_SET_OFFSET, SIZE_WORD,
                                         '0, 5'd0, 1'b0));
        // wraps past the window end
        request_queue.push_back(make_req(MODE_READ, 8'd252, 4'd8, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, 8'd0, 4'd3, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_WRITE, 8'd0, 4'd5,
                                         64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_WRITE, ENABLE_SET_OFFSET, 4'd2,
                                         64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_WRITE, PENDING_OFFSET, SIZE_WORD,
                                         64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, 8'd30, 4'd2, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_READ, 8'd255, 4'd1, '0, 5'd0, 1'b0));
        request_queue.push_back(make_req(MODE_LINE, 8'd0, 4'd0, '0, 5'd31, 1'b0));
        request_queue.push_back(make_req(MODE_WRITE, 8'd0, 4'd8, '0, 5'd0, 1'b0));

        // random part, mostly well-formed accesses
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            q.write_data  = {$urandom, $urandom};
            q.irq_number  = 5'($urandom);
            q.line_level  = 1'($urandom);
            q.address     = 8'($urandom);
            q.access_size = 4'd1 << $urandom_range(0, 3);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                q.mode = MODE_LINE;
            end
            else if (pick < 55) begin
                q.mode    = MODE_WRITE;
                q.address = 8'($urandom_range(0, ROUTE_LINES - 1));
            end
            else if (pick < 75) begin
                q.mode    = MODE_READ;
                q.address = 8'($urandom_range(0, 95));
            end
            else if (pick < 85) begin
                q.mode        = MODE_WRITE;
                q.address     = word_addr[$urandom_range(0, 2)];
                q.access_size = SIZE_WORD;
                // keep most lines enabled on a set
                if (q.address == ENABLE_SET_OFFSET)
                    q.write_data[31:0] = $urandom | $urandom;
            end
            else begin
                q.mode        = 2'($urandom_range(0, 2));
                q.access_size = 4'($urandom_range(1, 8));
            end
            request_queue.push_back(q);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || req_valid)
            @(posedge clk);
        while (outputs_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (error_count == 0 && outputs_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/irr_pkg.sv
rtl/irr_ctrl.sv
rtl/irr_dp.sv
rtl/interrupt_router_regs_unit.sv
rtl/irr_checker.sv
tb/sv/tb_interrupt_router_regs_unit.sv
